[rtl/rleb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rleb_pkg
// Shared types and constants of the run-length byte encoder.
// ----------------------------------------------------------------------------
package rleb_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] COUNT_FLAG    = 8'h80;
   localparam logic [6:0] MIN_RUN       = 7'd3;
   localparam logic [6:0] MAX_RUN_RESET = 7'd127;

   // One flush: a held group, then an optional single literal.
   typedef struct packed {
      logic [7:0] grp_value;
      logic [6:0] grp_count;
      logic       tail_valid;
      logic [7:0] tail_value;
      logic       block_end;
   } rleb_cmd_type;

endpackage
`default_nettype wire

[rtl/rleb_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rleb_front
// Accepts input beats, tracks the held group and issues flush commands.
// ----------------------------------------------------------------------------
module rleb_front
   import rleb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic         req_block_end,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_max_run,
   input  wire logic         queue_full,
   output logic              cmd_push,
   output rleb_cmd_type      cmd
);

   logic [6:0] max_run_ff;
   logic [7:0] held_value_ff, held_value_in;
   logic [6:0] held_count_ff, held_count_in;
   logic [6:0] limit;
   logic       accept;
   logic       extend;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign limit     = (max_run_ff < MIN_RUN) ? MIN_RUN : max_run_ff;
   assign extend    = (held_count_ff != 7'd0) && (req_in_byte == held_value_ff)
                      && (held_count_ff < limit);

   always_comb begin
      cmd.block_end  = req_block_end;
      cmd.tail_value = req_in_byte;
      held_value_in  = held_value_ff;
      held_count_in  = held_count_ff;
      if (extend) begin
         cmd.grp_value  = held_value_ff;
         cmd.grp_count  = held_count_ff + 7'd1;
         cmd.tail_valid = 1'b0;
         cmd_push       = accept && req_block_end;
         held_count_in  = held_count_ff + 7'd1;
      end else begin
         cmd.grp_value  = held_value_ff;
         cmd.grp_count  = held_count_ff;
         cmd.tail_valid = req_block_end;
         cmd_push       = accept && (req_block_end || (held_count_ff != 7'd0));
         held_value_in  = req_in_byte;
         held_count_in  = 7'd1;
      end
      if (req_block_end) begin
         held_value_in = 8'd0;
         held_count_in = 7'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff    <= MAX_RUN_RESET;
         held_value_ff <= 8'd0;
         held_count_ff <= 7'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_run_ff <= csr_max_run;
         end
         if (accept) begin
            held_value_ff <= held_value_in;
            held_count_ff <= held_count_in;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/rleb_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rleb_queue
// Small register queue of flush commands between front and back.
// ----------------------------------------------------------------------------
module rleb_queue
   import rleb_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  rleb_cmd_type      push_cmd,
   input  wire logic         pop,
   output rleb_cmd_type      head_cmd,
   output logic              full,
   output logic              empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rleb_cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/rleb_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rleb_back
// Expands the head flush command into encoded output beats, one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module rleb_back
   import rleb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  rleb_cmd_type      head_cmd,
   input  wire logic         queue_empty,
   output logic              queue_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_count,
   output logic              rsp_step_last,
   output logic              rsp_block_last
);

   logic [1:0] phase_ff;
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       is_count_ff, is_count_in;
   logic       step_last_ff;
   logic       block_last_ff;
   logic       is_run;
   logic [1:0] grp_n;
   logic [1:0] n_bytes;
   logic       last;
   logic       load;

   assign is_run  = (head_cmd.grp_count >= MIN_RUN);
   assign grp_n   = is_run ? 2'd2 : head_cmd.grp_count[1:0];
   assign n_bytes = grp_n + {1'b0, head_cmd.tail_valid};
   assign last    = (phase_ff == n_bytes - 2'd1);
   assign load    = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign queue_pop = load && last;

   always_comb begin
      out_byte_in = head_cmd.tail_value;
      is_count_in = 1'b0;
      if (phase_ff < grp_n) begin
         if (is_run && (phase_ff == 2'd0)) begin
            out_byte_in = {1'b0, head_cmd.grp_count} | COUNT_FLAG;
            is_count_in = 1'b1;
         end else begin
            out_byte_in = head_cmd.grp_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= out_byte_in;
         is_count_ff   <= is_count_in;
         step_last_ff  <= last;
         block_last_ff <= last && head_cmd.block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff     <= last ? 2'd0 : phase_ff + 2'd1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_is_count   = is_count_ff;
   assign rsp_step_last  = step_last_ff;
   assign rsp_block_last = block_last_ff;

endmodule
`default_nettype wire

[rtl/run_length_byte_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// Run-length byte encoder with a 7-bit count and a block end flag.
//
//   Channel   Dir   Handshake        Beat content
//   req_      in    valid / stall    in_byte, block_end
//   rsp_      out   valid / stall    out_byte, is_count, step_last, block_last
//   csr_      in    valid / ready    max_run
//
// One input beat per cycle while req_stall is low; the front classifies it in the same cycle.
// Output beats leave one per cycle from a registered stage while rsp_stall is low;
// each input causes zero to three of them, so sustained input rate follows output rate.
// Input stalls only while the command queue (QUEUE_DEPTH entries) is full.
// Synchronous reset clears held group, queue and output; max_run returns to 127.
// ----------------------------------------------------------------------------
module run_length_byte_encoder
   import rleb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic         req_block_end,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_count,
   output logic              rsp_step_last,
   output logic              rsp_block_last,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_max_run
);

   rleb_cmd_type push_cmd;
   rleb_cmd_type head_cmd;
   logic         push;
   logic         pop;
   logic         full;
   logic         empty;

   rleb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_block_end (req_block_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_max_run   (csr_max_run),
      .queue_full    (full),
      .cmd_push      (push),
      .cmd           (push_cmd)
   );

   rleb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (full),
      .empty    (empty)
   );

   rleb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .queue_empty    (empty),
      .queue_pop      (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_count   (rsp_is_count),
      .rsp_step_last  (rsp_step_last),
      .rsp_block_last (rsp_block_last)
   );

endmodule
`default_nettype wire
